// File: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// shared types, constants and blend helpers for the bilinear image scaler
// ----------------------------------------------------------------------------
package bis_pkg;

  // quotient bits kept by the coordinate dividers: the clamp limits stay below 2^28
  localparam int QW     = 29;
  localparam int CFG_W  = 13;
  localparam int ADDR_W = 24;
  localparam int QDEPTH = 2;
  localparam int HALF_TEXEL = 32768;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [0:0] REG_OUT_WIDTH  = 1'b0;
  localparam logic [0:0] REG_OUT_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd480;

  localparam logic [31:0] ALPHA_ON = 32'hFF000000;

  // one item as it moves through the divider stages
  typedef struct packed {
    logic             mode;
    logic [17:0]      idx;
    logic [23:0]      rgb;
    logic [11:0]      ox;
    logic [13:0]      plow;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] rem_x;
    logic [QW-1:0]    q_x;
    logic [CFG_W-1:0] rem_y;
    logic [QW-1:0]    q_y;
    logic             sat_y;
  } div_stage_t;

  typedef struct packed {
    logic             q;
    logic [CFG_W-1:0] rem;
  } div_res_t;

  // queue entry between front and back
  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
    logic [ADDR_W-1:0] addr_d;
    logic [23:0]       rgb;
    logic [7:0]        wx;
    logic [7:0]        wy;
  } qent_t;

  // one restoring division step
  function automatic div_res_t div_step(input logic [CFG_W-1:0] rem, input logic din,
                                        input logic [CFG_W-1:0] d);
    logic [CFG_W:0] sh;
    div_res_t       r;
    sh    = {rem, din};
    r.q   = (sh >= {1'b0, d});
    r.rem = r.q ? CFG_W'(sh - {1'b0, d}) : CFG_W'(sh);
    return r;
  endfunction

  function automatic logic [7:0] lerp8(input logic [7:0] p, input logic [7:0] q,
                                       input logic [7:0] w);
    logic [16:0] wp;
    logic [16:0] s;
    wp = 17'd256 - {9'd0, w};
    s  = ({9'd0, p} * wp) + ({9'd0, q} * {9'd0, w});
    return s[15:8];
  endfunction

  function automatic logic [23:0] lerp_rgb(input logic [23:0] p, input logic [23:0] q,
                                           input logic [7:0] w);
    return {lerp8(p[23:16], q[23:16], w), lerp8(p[15:8], q[15:8], w),
            lerp8(p[7:0], q[7:0], w)};
  endfunction

endpackage

// File: rtl/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// texel store with centre-aligned bilinear sampling to an output grid
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  input     start/busy, in_*                    beat when start and not busy
//  result    out_valid, out_pixel_argb           one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_wdata        write on cfg_we, no wait
//
//  one beat per cycle sustained while busy is low; a new beat enters before earlier samples leave
//  the coordinate divider has 29 stages, one quotient bit per stage
//  texel writes give no result; a write past the store is dropped
//  synchronous active-low reset clears control only, the texel store is not cleared
//  busy rises only when the front/back queue is full
// ----------------------------------------------------------------------------
module bilinear_image_scaler import bis_pkg::*; #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 384
) (
  input  logic             clk,
  input  logic             rst_n,
  // input beats
  input  logic             start,
  output logic             busy,
  input  logic             in_mode,
  input  logic [17:0]      in_texel_index,
  input  logic [23:0]      in_texel_rgb,
  input  logic [11:0]      in_out_x,
  input  logic [11:0]      in_out_y,
  // results
  output logic             out_valid,
  output logic [31:0]      out_pixel_argb,
  // configuration
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // output size registers, taken by each beat as it enters the front
  logic [CFG_W-1:0] width_r, width_nxt, height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_OUT_WIDTH:  width_nxt  = cfg_wdata;
        REG_OUT_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= OUT_WIDTH_RST;
      height_r <= OUT_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  logic  in_beat;
  logic  push;
  qent_t push_ent;
  logic  deq_valid;
  qent_t deq_ent;
  logic  q_full;

  // a beat is taken whenever start is up and the queue has room
  assign in_beat = start && !busy;
  assign busy    = q_full;

  // front: divide out the source position, build addresses
  bis_front #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid_i      (in_beat),
    .in_mode_i       (in_mode),
    .in_texel_index_i(in_texel_index),
    .in_texel_rgb_i  (in_texel_rgb),
    .in_out_x_i      (in_out_x),
    .in_out_y_i      (in_out_y),
    .out_width_i     (width_r),
    .out_height_i    (height_r),
    .push_o          (push),
    .push_ent_o      (push_ent)
  );

  // queue keeps writes and samples in order between the two halves
  bis_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_ent_i (push_ent),
    .deq_valid_o(deq_valid),
    .deq_ent_o  (deq_ent),
    .full_o     (q_full)
  );

  // back: store writes, four-texel fetch, blend
  bis_back #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .deq_valid_i(deq_valid),
    .deq_ent_i  (deq_ent),
    .out_valid_o(out_valid),
    .out_pixel_o(out_pixel_argb)
  );

endmodule

// File: rtl/bis_front.sv
// ----------------------------------------------------------------------------
// bis_front
// takes beats, divides out the source position and forms texel addresses
// ----------------------------------------------------------------------------
module bis_front import bis_pkg::*; #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 384
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  input  logic             in_mode_i,
  input  logic [17:0]      in_texel_index_i,
  input  logic [23:0]      in_texel_rgb_i,
  input  logic [11:0]      in_out_x_i,
  input  logic [11:0]      in_out_y_i,
  input  logic [CFG_W-1:0] out_width_i,
  input  logic [CFG_W-1:0] out_height_i,
  output logic             push_o,
  output qent_t            push_ent_o
);

  localparam int SHW   = $clog2(SRC_HEIGHT + 1);
  localparam int PW    = 13 + SHW;
  localparam int XW    = $clog2(SRC_WIDTH);
  localparam int YW    = $clog2(SRC_HEIGHT);
  localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int FXW   = 43;
  localparam logic [QW-1:0] DIVX   = QW'(SRC_WIDTH) << 16;
  localparam logic [QW-1:0] FX_MAX = QW'(SRC_WIDTH - 1) << 16;
  localparam logic [QW-1:0] FY_MAX = QW'(SRC_HEIGHT - 1) << 16;

  // stage 0: capture and set up both divisions
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [PW-1:0]    prod_y;
  div_stage_t       st_r [QW+1];
  div_stage_t       st0_nxt;
  logic [QW:0]      vld_r;

  assign w_eff  = (out_width_i == '0) ? CFG_W'(1) : out_width_i;
  assign h_eff  = (out_height_i == '0) ? CFG_W'(1) : out_height_i;
  assign prod_y = PW'({in_out_y_i, 1'b1}) * PW'(SRC_HEIGHT);

  always_comb begin
    st0_nxt       = '0;
    st0_nxt.mode  = in_mode_i;
    st0_nxt.idx   = in_texel_index_i;
    st0_nxt.rgb   = in_texel_rgb_i;
    st0_nxt.ox    = in_out_x_i;
    st0_nxt.plow  = prod_y[13:0];
    st0_nxt.w     = w_eff;
    st0_nxt.h     = h_eff;
    st0_nxt.rem_y = CFG_W'(prod_y >> 14);
    st0_nxt.sat_y = (32'(prod_y >> 14) >= 32'(h_eff));
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-1:0], in_valid_i};
    end
  end

  // one quotient bit of each division per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    div_res_t      dx, dy;
    logic [QW-1:0] nlow;
    div_stage_t    st_nxt;

    always_comb begin
      nlow         = {st_r[i].plow, 15'd0};
      dx           = div_step(st_r[i].rem_x, DIVX[QW-1-i], st_r[i].w);
      dy           = div_step(st_r[i].rem_y, nlow[QW-1-i], st_r[i].h);
      st_nxt       = st_r[i];
      st_nxt.rem_x = dx.rem;
      st_nxt.q_x   = {st_r[i].q_x[QW-2:0], dx.q};
      st_nxt.rem_y = dy.rem;
      st_nxt.q_y   = {st_r[i].q_y[QW-2:0], dy.q};
    end

    always_ff @(posedge clk) begin
      st_r[i+1] <= st_nxt;
    end
  end

  // m1: x position product
  logic            m1_vld_r, m1_mode_r, m1_sat_r;
  logic [17:0]     m1_idx_r;
  logic [23:0]     m1_rgb_r;
  logic [40:0]     m1_prod_r;
  logic [QW-2:0]   m1_half_r;
  logic [QW-1:0]   m1_qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    m1_mode_r <= st_r[QW].mode;
    m1_idx_r  <= st_r[QW].idx;
    m1_rgb_r  <= st_r[QW].rgb;
    m1_prod_r <= 41'(st_r[QW].ox) * 41'(st_r[QW].q_x);
    m1_half_r <= st_r[QW].q_x[QW-1:1];
    m1_qy_r   <= st_r[QW].q_y;
    m1_sat_r  <= st_r[QW].sat_y;
  end

  // m2: clamp and split into texel and weight
  logic [FXW-1:0] fx_s;
  logic [QW:0]    fy_s;
  logic [QW-1:0]  fxc, fyc;
  logic [XW-1:0]  x0_c, x1_c;
  logic [YW-1:0]  y0_c, y1_c;

  always_comb begin
    fx_s = FXW'(m1_prod_r) + FXW'(m1_half_r) - FXW'(HALF_TEXEL);
    if (fx_s[FXW-1]) begin
      fxc = '0;
    end else if (fx_s > FXW'(FX_MAX)) begin
      fxc = FX_MAX;
    end else begin
      fxc = fx_s[QW-1:0];
    end
    fy_s = (QW+1)'(m1_qy_r) - (QW+1)'(HALF_TEXEL);
    if (m1_sat_r) begin
      fyc = FY_MAX;
    end else if (fy_s[QW]) begin
      fyc = '0;
    end else if (fy_s[QW-1:0] > FY_MAX) begin
      fyc = FY_MAX;
    end else begin
      fyc = fy_s[QW-1:0];
    end
    x0_c = fxc[16 +: XW];
    y0_c = fyc[16 +: YW];
    x1_c = (((XW+1)'(x0_c) + (XW+1)'(1)) < (XW+1)'(SRC_WIDTH)) ? XW'(x0_c + 1'b1) : x0_c;
    y1_c = (((YW+1)'(y0_c) + (YW+1)'(1)) < (YW+1)'(SRC_HEIGHT)) ? YW'(y0_c + 1'b1) : y0_c;
  end

  logic          m2_vld_r, m2_mode_r;
  logic [17:0]   m2_idx_r;
  logic [23:0]   m2_rgb_r;
  logic [XW-1:0] m2_x0_r, m2_x1_r;
  logic [YW-1:0] m2_y0_r, m2_y1_r;
  logic [7:0]    m2_wx_r, m2_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_mode_r <= m1_mode_r;
    m2_idx_r  <= m1_idx_r;
    m2_rgb_r  <= m1_rgb_r;
    m2_x0_r   <= x0_c;
    m2_x1_r   <= x1_c;
    m2_y0_r   <= y0_c;
    m2_y1_r   <= y1_c;
    m2_wx_r   <= fxc[15:8];
    m2_wy_r   <= fyc[15:8];
  end

  // m3: row bases and queue entry
  logic [AW-1:0] row0, row1;
  qent_t         ent_nxt, ent_r;
  logic          push_nxt, push_r;

  always_comb begin
    row0           = AW'(m2_y0_r) * AW'(SRC_WIDTH);
    row1           = AW'(m2_y1_r) * AW'(SRC_WIDTH);
    ent_nxt.wr     = (m2_mode_r == MODE_WRITE);
    ent_nxt.rgb    = m2_rgb_r;
    ent_nxt.wx     = m2_wx_r;
    ent_nxt.wy     = m2_wy_r;
    ent_nxt.addr_b = ADDR_W'(row0 + AW'(m2_x1_r));
    ent_nxt.addr_c = ADDR_W'(row1 + AW'(m2_x0_r));
    ent_nxt.addr_d = ADDR_W'(row1 + AW'(m2_x1_r));
    if (m2_mode_r == MODE_WRITE) begin
      ent_nxt.addr_a = ADDR_W'(m2_idx_r);
    end else begin
      ent_nxt.addr_a = ADDR_W'(row0 + AW'(m2_x0_r));
    end
    // out-of-range writes are dropped here
    push_nxt = m2_vld_r && ((m2_mode_r == MODE_SAMPLE) || (32'(m2_idx_r) < 32'(DEPTH)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= push_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign push_o     = push_r;
  assign push_ent_o = ent_r;

endmodule

// File: rtl/bis_queue.sv
// ----------------------------------------------------------------------------
// bis_queue
// short queue between the address front and the texel back
// ----------------------------------------------------------------------------
module bis_queue import bis_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  qent_t push_ent_i,
  output logic  deq_valid_o,
  output qent_t deq_ent_o,
  output logic  full_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t            ent_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  // the back never stalls, so anything held leaves at once
  assign pop = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push_i ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CNT_W'(cnt_r + CNT_W'(push_i) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= push_ent_i;
    end
  end

  assign deq_valid_o = pop;
  assign deq_ent_o   = ent_r[rd_ptr_r];
  assign full_o      = (cnt_r == CNT_W'(QDEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("queue push while full");

  a_empty_push_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && cnt_r == '0) |=> deq_valid_o)
    else $error("queue entry not presented after push into empty queue");
`endif

endmodule

// File: rtl/bis_back.sv
// ----------------------------------------------------------------------------
// bis_back
// texel store, four-texel fetch and blend
// ----------------------------------------------------------------------------
module bis_back import bis_pkg::*; #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        deq_valid_i,
  input  qent_t       deq_ent_i,
  output logic        out_valid_o,
  output logic [31:0] out_pixel_o
);

  localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // two copies, two read ports each: top row pair and bottom row pair
  logic [23:0] mem_top [DEPTH];
  logic [23:0] mem_bot [DEPTH];

  logic [23:0] tex_a_r, tex_b_r, tex_c_r, tex_d_r;
  logic        s1_smp_r, s2_smp_r, out_valid_r;
  logic [7:0]  s1_wx_r, s1_wy_r, s2_wy_r;
  logic [23:0] s2_top_r, s2_bot_r;
  logic [31:0] pixel_r;

  always_ff @(posedge clk) begin
    if (deq_valid_i && deq_ent_i.wr) begin
      mem_top[deq_ent_i.addr_a[AW-1:0]] <= deq_ent_i.rgb;
      mem_bot[deq_ent_i.addr_a[AW-1:0]] <= deq_ent_i.rgb;
    end
  end

  always_ff @(posedge clk) begin
    tex_a_r <= mem_top[deq_ent_i.addr_a[AW-1:0]];
    tex_b_r <= mem_top[deq_ent_i.addr_b[AW-1:0]];
    tex_c_r <= mem_bot[deq_ent_i.addr_c[AW-1:0]];
    tex_d_r <= mem_bot[deq_ent_i.addr_d[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r    <= 1'b0;
      s2_smp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_smp_r    <= deq_valid_i && !deq_ent_i.wr;
      s2_smp_r    <= s1_smp_r;
      out_valid_r <= s2_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_wx_r  <= deq_ent_i.wx;
    s1_wy_r  <= deq_ent_i.wy;
    s2_top_r <= lerp_rgb(tex_a_r, tex_b_r, s1_wx_r);
    s2_bot_r <= lerp_rgb(tex_c_r, tex_d_r, s1_wx_r);
    s2_wy_r  <= s1_wy_r;
    pixel_r  <= ALPHA_ON | {8'd0, lerp_rgb(s2_top_r, s2_bot_r, s2_wy_r)};
  end

  assign out_valid_o = out_valid_r;
  assign out_pixel_o = pixel_r;

`ifndef SYNTHESIS
  a_sample_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s1_smp_r |-> ##2 out_valid_o)
    else $error("fetched sample did not produce a pixel");
`endif

endmodule

// File: test/bilinear_image_scaler_tb.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_tb
// self-checking bench: texel writes and samples under random bursts and gaps,
// several output sizes, every pixel checked against a behavioral blend
// ----------------------------------------------------------------------------
module bilinear_image_scaler_tb;
  import bis_pkg::*;

  localparam int SRC_W      = 512;
  localparam int SRC_H      = 384;
  localparam int DEPTH      = SRC_W * SRC_H;
  localparam int DRAIN_WAIT = 60;    // a little past the sample latency of the pipeline
  localparam int STALL_MAX  = 5000;  // cycles with no beat either way

  // scoreboard: mirror of the texel store and size registers plus pixel queue
  class pixel_scoreboard;
    logic [23:0] texels [int];
    int unsigned w_reg;
    int unsigned h_reg;
    logic [31:0] pixel_q [$];
    int          errors;
    int          pixels_seen;
    int          writes_seen;

    function new();
      w_reg = OUT_WIDTH_RST;
      h_reg = OUT_HEIGHT_RST;
    endfunction

    function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] v);
      if (idx == REG_OUT_WIDTH) w_reg = v;
      else h_reg = v;
    endfunction

    // map an output pixel to its four source addresses and blend weights
    function void locate(input logic [11:0] ox, input logic [11:0] oy,
                         output int unsigned ad [4], output int unsigned wx,
                         output int unsigned wy);
      longint w, h, stepx, fx, fy;
      int unsigned x0, y0, x1, y1;
      w = (w_reg != 0) ? w_reg : 1;
      h = (h_reg != 0) ? h_reg : 1;
      stepx = (longint'(SRC_W) * 65536) / w;
      fx = (longint'(SRC_W) * 32768) / w - HALF_TEXEL + longint'(ox) * stepx;
      fy = ((2 * longint'(oy) + 1) * SRC_H * 32768) / h - HALF_TEXEL;
      if (fx < 0) fx = 0;
      if (fx > longint'(SRC_W - 1) * 65536) fx = longint'(SRC_W - 1) * 65536;
      if (fy < 0) fy = 0;
      if (fy > longint'(SRC_H - 1) * 65536) fy = longint'(SRC_H - 1) * 65536;
      x0 = fx >> 16;
      y0 = fy >> 16;
      x1 = (x0 + 1 < SRC_W) ? x0 + 1 : x0;
      y1 = (y0 + 1 < SRC_H) ? y0 + 1 : y0;
      wx = (fx >> 8) & 255;
      wy = (fy >> 8) & 255;
      ad[0] = y0 * SRC_W + x0;
      ad[1] = y0 * SRC_W + x1;
      ad[2] = y1 * SRC_W + x0;
      ad[3] = y1 * SRC_W + x1;
    endfunction

    function logic [23:0] blend(logic [23:0] p, logic [23:0] q, int unsigned wq);
      logic [23:0] r;
      for (int c = 0; c < 3; c++)
        r[c*8 +: 8] = (p[c*8 +: 8] * (256 - wq) + q[c*8 +: 8] * wq) >> 8;
      return r;
    endfunction

    function void note_beat(logic mode, logic [17:0] idx, logic [23:0] rgb,
                            logic [11:0] ox, logic [11:0] oy);
      int unsigned ad [4];
      int unsigned wx, wy;
      if (mode == MODE_WRITE) begin
        if (idx < DEPTH) texels[idx] = rgb;
        writes_seen++;
      end else begin
        locate(ox, oy, ad, wx, wy);
        pixel_q.push_back(ALPHA_ON | blend(blend(texels[ad[0]], texels[ad[1]], wx),
                                           blend(texels[ad[2]], texels[ad[3]], wx), wy));
      end
    endfunction

    function void check_pixel(logic [31:0] act);
      logic [31:0] exp_px;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel beat, actual %08h", $time, act);
        errors++;
      end else begin
        exp_px = pixel_q.pop_front();
        pixels_seen++;
        if (act !== exp_px) begin
          $display("%0t: pixel mismatch, expected %08h actual %08h", $time, exp_px, act);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_mode;
  logic [17:0]      in_texel_index;
  logic [23:0]      in_texel_rgb;
  logic [11:0]      in_out_x;
  logic [11:0]      in_out_y;
  logic             out_valid;
  logic [31:0]      out_pixel_argb;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  pixel_scoreboard sb;
  int  idle_cycles;
  int  burst_left;
  bit  no_gaps;

  bilinear_image_scaler #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_texel_index (in_texel_index),
    .in_texel_rgb   (in_texel_rgb),
    .in_out_x       (in_out_x),
    .in_out_y       (in_out_y),
    .out_valid      (out_valid),
    .out_pixel_argb (out_pixel_argb),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: every strobe is a beat, no back-pressure possible
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_pixel(out_pixel_argb);
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat, held until accepted, then maybe a gap
  task automatic send_beat(logic mode, logic [17:0] idx, logic [23:0] rgb,
                           logic [11:0] ox, logic [11:0] oy);
    int gap;
    start          <= 1'b1;
    in_mode        <= mode;
    in_texel_index <= idx;
    in_texel_rgb   <= rgb;
    in_out_x       <= ox;
    in_out_y       <= oy;
    do @(posedge clk); while (busy);
    sb.note_beat(mode, idx, rgb, ox, oy);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        // end of burst: drop start for a random gap
        gap = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_texel(logic [17:0] idx, logic [23:0] rgb);
    send_beat(MODE_WRITE, idx, rgb, 12'($urandom), 12'($urandom));
  endtask

  // a sample never touches an unwritten texel: fill its neighbors first
  task automatic sample_pixel(logic [11:0] ox, logic [11:0] oy);
    int unsigned ad [4];
    int unsigned wx, wy;
    sb.locate(ox, oy, ad, wx, wy);
    for (int k = 0; k < 4; k++)
      if (!sb.texels.exists(ad[k])) write_texel(18'(ad[k]), 24'($urandom));
    send_beat(MODE_SAMPLE, 18'($urandom), 24'($urandom), ox, oy);
  endtask

  // let every pending pixel arrive plus the pipeline tail
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pixel_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_OUT_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.set_reg(REG_OUT_WIDTH, w);
    cfg_index <= REG_OUT_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.set_reg(REG_OUT_HEIGHT, h);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random mix: mostly samples inside the image, some anywhere, plus writes
  task automatic random_phase(int n);
    int unsigned wl, hl, pick;
    wl = (sb.w_reg == 0) ? 1 : ((sb.w_reg > 4096) ? 4096 : sb.w_reg);
    hl = (sb.h_reg == 0) ? 1 : ((sb.h_reg > 4096) ? 4096 : sb.h_reg);
    for (int i = 0; i < n; i++) begin
      no_gaps = ((i / 3) % 3) == 2;  // every third stretch runs back to back
      pick = $urandom_range(0, 99);
      if (pick < 60)
        sample_pixel(12'($urandom_range(0, wl - 1)), 12'($urandom_range(0, hl - 1)));
      else if (pick < 75)
        sample_pixel(12'($urandom), 12'($urandom));
      else
        write_texel(18'($urandom), 24'($urandom));
    end
  endtask

  logic [CFG_W-1:0] size_w [8];
  logic [CFG_W-1:0] size_h [8];

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_WRITE;
    in_texel_index = '0;
    in_texel_rgb   = '0;
    in_out_x       = '0;
    in_out_y       = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_OUT_WIDTH;
    cfg_wdata      = '0;
    burst_left     = 4;
    no_gaps        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: store corners, dropped writes, colour extremes, image corners
    write_texel(18'd0, 24'h000000);
    write_texel(18'(DEPTH - 1), 24'hFFFFFF);
    write_texel(18'(DEPTH), 24'h123456);        // one past the store, dropped
    write_texel(18'h3FFFF, 24'hABCDEF);         // top of the index range, dropped
    write_texel(18'd1, 24'hFFFFFF);
    write_texel(18'(SRC_W), 24'hFF00FF);
    write_texel(18'(SRC_W + 1), 24'h00FF00);
    sample_pixel(12'd0, 12'd0);                 // clamp at the top-left
    sample_pixel(12'd639, 12'd479);             // last pixel at reset size
    sample_pixel(12'd4095, 12'd4095);           // far outside, clamp bottom-right
    sample_pixel(12'd640, 12'd0);
    sample_pixel(12'd320, 12'd240);
    sample_pixel(12'd1, 12'd1);

    // pause with everything drained before going random
    drain();
    random_phase(10);

    size_w = '{13'd1,    13'd0, 13'd8191, 13'd4096, 13'd512, 13'd1024, 13'd7, 13'd0};
    size_h = '{13'd1,    13'd0, 13'd8191, 13'd4096, 13'd384, 13'd768,  13'd3, 13'd0};
    size_w[7] = 13'($urandom_range(1, 4096));
    size_h[7] = 13'($urandom_range(1, 4096));
    for (int p = 0; p < 8; p++) begin
      set_size(size_w[p], size_h[p]);
      sample_pixel(12'd0, 12'd0);
      sample_pixel(12'd4095, 12'd4095);
      random_phase(10);
    end

    drain();
    $display("covered %0d texel writes and %0d checked pixels over 9 output sizes",
             sb.writes_seen, sb.pixels_seen);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
